// ===== hdl/tfd_pkg.sv =====
// Package for the timed feed dispense sequencer.
// Holds the payload and configuration types, event and slot codes, and reset constants.
// No dependencies.
package tfd_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_TICKS_PER_SECOND      = 3'd0;
   localparam logic [2:0] CSR_WEIGHT_THRESHOLD      = 3'd1;
   localparam logic [2:0] CSR_REFILL_CYCLE_LIMIT    = 3'd2;
   localparam logic [2:0] CSR_INTERVAL_AFTER_FIRST  = 3'd3;
   localparam logic [2:0] CSR_INTERVAL_AFTER_SECOND = 3'd4;
   localparam logic [2:0] CSR_INTERVAL_AFTER_THIRD  = 3'd5;
   localparam logic [2:0] CSR_SERVO_OPEN_PULSE      = 3'd6;
   localparam logic [2:0] CSR_SERVO_CLOSED_PULSE    = 3'd7;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   // Register reset values
   localparam logic [15:0] TPS_RST          = 16'd1000;
   localparam logic [9:0]  THRESHOLD_RST    = 10'd1000;
   localparam logic [7:0]  CYCLE_LIMIT_RST  = 8'd10;
   localparam logic [5:0]  INTERVAL_1_RST   = 6'd1;
   localparam logic [5:0]  INTERVAL_2_RST   = 6'd2;
   localparam logic [5:0]  INTERVAL_3_RST   = 6'd5;
   localparam logic [15:0] OPEN_PULSE_RST   = 16'd500;
   localparam logic [15:0] CLOSED_PULSE_RST = 16'd2425;

   // State reset values and limits
   localparam logic [5:0]  SECONDS_RST   = 6'd5;
   localparam logic [15:0] SERVO_RST     = 16'd1500;
   localparam logic [5:0]  FIELD_WRAP    = 6'd59;
   localparam logic [1:0]  PASS_MAX      = 2'd3;
   localparam logic [1:0]  PASS_NEEDED   = 2'd2;
   localparam logic [7:0]  CYCLE_MAX     = 8'd255;

   // Function codes of an input item
   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // Event codes of a result item
   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_SECOND = 3'd1;
   localparam logic [2:0] EV_START  = 3'd2;
   localparam logic [2:0] EV_READY  = 3'd3;
   localparam logic [2:0] EV_REFILL = 3'd4;

   // Meal rotation slots
   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;

   typedef struct packed {
      logic       func;
      logic [9:0] weight_sample;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [4:0]  shown_hours;
      logic [5:0]  shown_minutes;
      logic [5:0]  shown_seconds;
      logic [15:0] servo_pulse;
      logic        green_led;
      logic        red_led;
      logic        dispensing;
   } rsp_type;

   typedef struct packed {
      logic [15:0] ticks_per_second;
      logic [9:0]  weight_threshold;
      logic [7:0]  refill_cycle_limit;
      logic [5:0]  interval_after_first;
      logic [5:0]  interval_after_second;
      logic [5:0]  interval_after_third;
      logic [15:0] servo_open_pulse;
      logic [15:0] servo_closed_pulse;
   } cfg_type;

endpackage

// ===== hdl/tfd_req_if.sv =====
// Valid/ready channel carrying input items (ticks and weight samples).
// Depends on tfd_pkg.
interface tfd_req_if;
   logic             valid;
   logic             ready;
   tfd_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/tfd_rsp_if.sv =====
// Valid/ready channel carrying result items.
// Depends on tfd_pkg.
interface tfd_rsp_if;
   logic             valid;
   logic             ready;
   tfd_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/tfd_csr.sv =====
// Configuration register bank, write only.
// Depends on tfd_pkg.
module tfd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tfd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output tfd_pkg::cfg_type                    cfg
);

   tfd_pkg::cfg_type cfg_ff;
   tfd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tfd_pkg::CSR_TICKS_PER_SECOND:      cfg_in.ticks_per_second      = csr_wdata;
            tfd_pkg::CSR_WEIGHT_THRESHOLD:      cfg_in.weight_threshold      = csr_wdata[9:0];
            tfd_pkg::CSR_REFILL_CYCLE_LIMIT:    cfg_in.refill_cycle_limit    = csr_wdata[7:0];
            tfd_pkg::CSR_INTERVAL_AFTER_FIRST:  cfg_in.interval_after_first  = csr_wdata[5:0];
            tfd_pkg::CSR_INTERVAL_AFTER_SECOND: cfg_in.interval_after_second = csr_wdata[5:0];
            tfd_pkg::CSR_INTERVAL_AFTER_THIRD:  cfg_in.interval_after_third  = csr_wdata[5:0];
            tfd_pkg::CSR_SERVO_OPEN_PULSE:      cfg_in.servo_open_pulse      = csr_wdata;
            tfd_pkg::CSR_SERVO_CLOSED_PULSE:    cfg_in.servo_closed_pulse    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_second      <= tfd_pkg::TPS_RST;
         cfg_ff.weight_threshold      <= tfd_pkg::THRESHOLD_RST;
         cfg_ff.refill_cycle_limit    <= tfd_pkg::CYCLE_LIMIT_RST;
         cfg_ff.interval_after_first  <= tfd_pkg::INTERVAL_1_RST;
         cfg_ff.interval_after_second <= tfd_pkg::INTERVAL_2_RST;
         cfg_ff.interval_after_third  <= tfd_pkg::INTERVAL_3_RST;
         cfg_ff.servo_open_pulse      <= tfd_pkg::OPEN_PULSE_RST;
         cfg_ff.servo_closed_pulse    <= tfd_pkg::CLOSED_PULSE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/tfd_core.sv =====
// Sequencer state and its combinational update for one item.
// Depends on tfd_pkg.
module tfd_core (
   input  logic             clock,
   input  logic             reset,
   input  tfd_pkg::cfg_type cfg,
   input  logic             step,
   input  tfd_pkg::req_type item,
   output tfd_pkg::rsp_type result
);

   logic [15:0] tick_count_ff, tick_count_in;
   logic [5:0]  seconds_ff, seconds_in;
   logic [5:0]  minutes_ff, minutes_in;
   logic [4:0]  hours_ff, hours_in;
   logic [1:0]  slot_ff, slot_in;
   logic        dispense_ff, dispense_in;
   logic        second_half_ff, second_half_in;
   logic [1:0]  pass_ff, pass_in;
   logic [7:0]  cycle_ff, cycle_in;
   logic [15:0] servo_ff, servo_in;
   logic        green_ff, green_in;
   logic        red_ff, red_in;

   logic [15:0] tick_inc;
   logic [1:0]  pass_judged;
   logic [2:0]  ev;
   logic        green_show;

   assign tick_inc = tick_count_ff + 16'd1;

   // Sample judgement: pass count saturates, a fail clears it
   always_comb begin
      if (item.weight_sample > cfg.weight_threshold) begin
         pass_judged = (pass_ff == tfd_pkg::PASS_MAX) ? pass_ff : pass_ff + 2'd1;
      end else begin
         pass_judged = 2'd0;
      end
   end

   always_comb begin
      tick_count_in  = tick_count_ff;
      seconds_in     = seconds_ff;
      minutes_in     = minutes_ff;
      hours_in       = hours_ff;
      slot_in        = slot_ff;
      dispense_in    = dispense_ff;
      second_half_in = second_half_ff;
      pass_in        = pass_ff;
      cycle_in       = cycle_ff;
      servo_in       = servo_ff;
      green_in       = green_ff;
      red_in         = red_ff;
      ev             = tfd_pkg::EV_NONE;
      green_show     = 1'b0;

      if (!dispense_ff && item.func == tfd_pkg::FUNC_TICK) begin
         tick_count_in = tick_inc;
         if (tick_inc == cfg.ticks_per_second) begin
            tick_count_in = 16'd0;
            ev            = tfd_pkg::EV_SECOND;
            if (seconds_ff != 6'd0) begin
               seconds_in = seconds_ff - 6'd1;
            end else if (minutes_ff != 6'd0) begin
               seconds_in = tfd_pkg::FIELD_WRAP;
               minutes_in = minutes_ff - 6'd1;
            end else if (hours_ff != 5'd0) begin
               seconds_in = tfd_pkg::FIELD_WRAP;
               minutes_in = tfd_pkg::FIELD_WRAP;
               hours_in   = hours_ff - 5'd1;
            end else begin
               ev             = tfd_pkg::EV_START;
               dispense_in    = 1'b1;
               second_half_in = 1'b0;
               pass_in        = 2'd0;
               cycle_in       = 8'd0;
               green_in       = 1'b1;
            end
         end
      end else if (dispense_ff && item.func == tfd_pkg::FUNC_SAMPLE) begin
         pass_in = pass_judged;
         if (!second_half_ff) begin
            // Open move of the cycle
            if (cycle_ff != tfd_pkg::CYCLE_MAX) begin
               cycle_in = cycle_ff + 8'd1;
            end
            servo_in       = cfg.servo_open_pulse;
            second_half_in = 1'b1;
         end else begin
            // Closed move: decide the cycle
            servo_in       = cfg.servo_closed_pulse;
            second_half_in = 1'b0;
            if (pass_judged >= tfd_pkg::PASS_NEEDED) begin
               ev          = tfd_pkg::EV_READY;
               green_show  = 1'b1;
               green_in    = 1'b0;
               red_in      = 1'b0;
               dispense_in = 1'b0;
               hours_in    = 5'd0;
               seconds_in  = 6'd0;
               case (slot_ff)
                  tfd_pkg::SLOT_FIRST: begin
                     minutes_in = cfg.interval_after_first;
                     slot_in    = tfd_pkg::SLOT_SECOND;
                  end
                  tfd_pkg::SLOT_SECOND: begin
                     minutes_in = cfg.interval_after_second;
                     slot_in    = tfd_pkg::SLOT_THIRD;
                  end
                  default: begin
                     minutes_in = cfg.interval_after_third;
                     slot_in    = tfd_pkg::SLOT_FIRST;
                  end
               endcase
            end else if (cycle_ff >= cfg.refill_cycle_limit) begin
               ev       = tfd_pkg::EV_REFILL;
               green_in = 1'b0;
               red_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff  <= 16'd0;
         seconds_ff     <= tfd_pkg::SECONDS_RST;
         minutes_ff     <= 6'd0;
         hours_ff       <= 5'd0;
         slot_ff        <= tfd_pkg::SLOT_FIRST;
         dispense_ff    <= 1'b0;
         second_half_ff <= 1'b0;
         pass_ff        <= 2'd0;
         cycle_ff       <= 8'd0;
         servo_ff       <= tfd_pkg::SERVO_RST;
         green_ff       <= 1'b0;
         red_ff         <= 1'b0;
      end else if (step) begin
         tick_count_ff  <= tick_count_in;
         seconds_ff     <= seconds_in;
         minutes_ff     <= minutes_in;
         hours_ff       <= hours_in;
         slot_ff        <= slot_in;
         dispense_ff    <= dispense_in;
         second_half_ff <= second_half_in;
         pass_ff        <= pass_in;
         cycle_ff       <= cycle_in;
         servo_ff       <= servo_in;
         green_ff       <= green_in;
         red_ff         <= red_in;
      end
   end

   // Shown time is the countdown as it stood before this item
   always_comb begin
      result.event_res     = ev;
      result.shown_hours   = hours_ff;
      result.shown_minutes = minutes_ff;
      result.shown_seconds = seconds_ff;
      result.servo_pulse   = servo_in;
      result.green_led     = green_show | green_in;
      result.red_led       = red_in;
      result.dispensing    = dispense_in;
   end

endmodule

// ===== hdl/timed_feed_dispense_sequencer.sv =====
// Timed feed dispense sequencer, top level.
// An item passes the input register, then its result the result register, before the
// result is offered. Throughput: one item per cycle while the consumer does not stall;
// the whole update is one pass of the core logic.
// Reset (synchronous, active high): both registers empty, register defaults, 0:0:5 countdown,
// first meal slot, servo at 1500. Uses tfd_pkg, the channel interfaces, tfd_csr, tfd_core.
module timed_feed_dispense_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   tfd_req_if.sink                         req_ch,
   tfd_rsp_if.source                       rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [tfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tfd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tfd_pkg::cfg_type cfg;

   // Input register: holds one accepted item until the core takes it
   logic             in_valid_ff, in_valid_in;
   tfd_pkg::req_type in_item_ff;

   // Result register: parts the core from a stalled consumer
   logic             rsp_valid_ff, rsp_valid_in;
   tfd_pkg::rsp_type rsp_data_ff;
   tfd_pkg::rsp_type core_result;

   logic out_free;
   logic advance;
   logic req_xfer;

   // The result register can be loaded when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   // Core steps on the held item whenever its result has somewhere to go
   assign advance  = in_valid_ff && out_free;
   // Input register frees up in the same cycle its item advances
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= req_ch.payload;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   tfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tfd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .item   (in_item_ff),
      .result (core_result)
   );

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

endmodule
